FILE: rtl/rfwd_pkg.sv
package rfwd_pkg;

   localparam int SOURCES = 15;
   localparam int WORD_BYTES = 6;
   localparam int CHIPS_PER_SOURCE_DEF = 32;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int TIME_W = 42;
   localparam int CHIP_W = 5;

   localparam logic [15:0] MAX_HITS_RESET = 16'd1024;
   localparam logic [15:0] MIN_FRAME_BYTES = 16'd4;
   localparam logic [31:0] END_PATTERN = 32'hfafafafa;
   localparam logic [31:0] SIG_MASK = 32'hffffff00;
   localparam logic [31:0] SIG_VALUE = 32'h564d3300;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_HIT = 2'd1;
   localparam logic [1:0] KIND_MARKER = 2'd2;
   localparam logic [1:0] KIND_DROP = 2'd3;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_END = 3'd1;
   localparam logic [2:0] STATUS_UNDERSIZE = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN_ID = 3'd3;
   localparam logic [2:0] STATUS_BAD_FE = 3'd4;
   localparam logic [2:0] STATUS_BAD_LENGTH = 3'd5;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        status;
      logic              seq_err;
      logic [CHIP_W-1:0] chip;
      logic              slot_ok;
   } frame_dec_type;

   function automatic logic [11:0] gray_to_bin(input logic [11:0] g);
      logic [11:0] b;
      b[11] = g[11];
      for (int i = 10; i >= 0; i--) begin
         b[i] = b[i+1] ^ g[i];
      end
      return b;
   endfunction

   // Four is one modulo three, so the base-four digits sum to the same residue.
   function automatic logic mod3_zero(input logic [15:0] x);
      logic [4:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + {3'b000, x[2*i +: 2]};
      end
      return s inside {5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24};
   endfunction

endpackage

FILE: rtl/rfwd_ram.sv
module rfwd_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 480
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rfwd_frame.sv
module rfwd_frame
   import rfwd_pkg::*;
#(
   parameter int CHIPS_PER_SOURCE = CHIPS_PER_SOURCE_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              req_type,
   input  logic [31:0]       frame_counter,
   input  logic [31:0]       data_id,
   input  logic [15:0]       frame_bytes,
   input  logic [31:0]       word_high,
   input  logic [15:0]       word_low,
   input  logic [15:0]       max_hits,
   output frame_dec_type     dec,
   output logic [ADDR_W-1:0] slot
);

   localparam logic [15:0] MIN_BYTES = 16'(HEADER_BYTES + WORD_BYTES);
   localparam logic [15:0] HDR_BYTES = 16'(HEADER_BYTES);
   localparam logic [5:0] CHIP_LIMIT = 6'(CHIPS_PER_SOURCE);
   localparam logic [ADDR_W-1:0] CHIP_STRIDE = ADDR_W'(CHIPS_PER_SOURCE);

   logic [31:0] expected_ff, expected_in;
   logic [3:0]  source_ff, source_in;
   logic        open_ff, open_in;
   logic [15:0] hits_ff, hits_in;

   logic [31:0]       exp_next;
   logic [2:0]        status;
   logic              seq_err;
   logic [15:0]       payload_bytes;
   logic              len_ok;
   logic              in_frame;
   logic [CHIP_W-1:0] chip;

   assign payload_bytes = frame_bytes - HDR_BYTES;
   assign len_ok = !payload_bytes[0] && mod3_zero(payload_bytes);

   always_comb begin
      seq_err = 1'b0;
      exp_next = expected_ff;
      if (frame_bytes < MIN_FRAME_BYTES) begin
         status = STATUS_UNDERSIZE;
      end else if (frame_counter == END_PATTERN) begin
         status = STATUS_END;
      end else begin
         seq_err = frame_counter != expected_ff;
         exp_next = frame_counter + 32'd1;
         if (frame_bytes < MIN_BYTES) begin
            status = STATUS_UNDERSIZE;
         end else if ((data_id & SIG_MASK) != SIG_VALUE) begin
            status = STATUS_UNKNOWN_ID;
         end else if (data_id[7:4] == 4'd0) begin
            status = STATUS_BAD_FE;
         end else if (!len_ok) begin
            status = STATUS_BAD_LENGTH;
         end else begin
            status = STATUS_OK;
         end
      end
   end

   assign in_frame = open_ff && (hits_ff < max_hits);
   assign chip = word_low[15] ? word_high[26:22] : word_low[14:10];

   always_comb begin
      dec.status = status;
      dec.seq_err = seq_err;
      dec.chip = chip;
      dec.slot_ok = (source_ff != 4'd0) && ({1'b0, chip} < CHIP_LIMIT);
      if (!req_type) begin
         dec.kind = KIND_HEADER;
      end else if (!in_frame) begin
         dec.kind = KIND_DROP;
      end else if (word_low[15]) begin
         dec.kind = KIND_HIT;
      end else begin
         dec.kind = KIND_MARKER;
      end
   end

   assign slot = ADDR_W'((ADDR_W'(source_ff) - ADDR_W'(1)) * CHIP_STRIDE) + ADDR_W'(chip);

   always_comb begin
      expected_in = expected_ff;
      source_in = source_ff;
      open_in = open_ff;
      hits_in = hits_ff;
      if (accept) begin
         case (dec.kind)
            KIND_HEADER: begin
               expected_in = exp_next;
               open_in = status == STATUS_OK;
               hits_in = '0;
               if (status == STATUS_OK) begin
                  source_in = data_id[7:4];
               end
            end
            KIND_HIT: begin
               hits_in = hits_ff + 16'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         source_ff <= '0;
         open_ff <= 1'b0;
         hits_ff <= '0;
      end else begin
         expected_ff <= expected_in;
         source_ff <= source_in;
         open_ff <= open_in;
         hits_ff <= hits_in;
      end
   end

endmodule

FILE: rtl/readout_frame_word_decoder.sv
// Decodes a stream of frame headers and 48-bit readout words into one result beat per
// input beat. A header is checked and answered with a status and a sequence flag; a
// passing header opens a frame, in which markers store a 42-bit timestamp per front-end
// and chip and hits are decoded with the stored timestamp attached. Timestamps live in
// one synchronous RAM of 15 * CHIPS_PER_SOURCE entries, which after reset the block
// clears entry by entry while holding req_stall high. Then one beat is accepted every
// cycle while rsp_stall is low; each result is registered in s1, where the RAM is read,
// then in the result registers. max_hits must be written only while no beats are in
// flight; csr_ready is tied high, so the block itself does not enforce this.
module readout_frame_word_decoder
   import rfwd_pkg::*;
#(
   parameter int CHIPS_PER_SOURCE = CHIPS_PER_SOURCE_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_max_hits,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_type,
   input  logic [31:0]       req_frame_counter,
   input  logic [31:0]       req_data_id,
   input  logic [15:0]       req_frame_bytes,
   input  logic [31:0]       req_word_high,
   input  logic [15:0]       req_word_low,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_item_kind,
   output logic [2:0]        rsp_frame_status,
   output logic              rsp_sequence_error,
   output logic              rsp_over_threshold,
   output logic [5:0]        rsp_channel,
   output logic [7:0]        rsp_tdc_value,
   output logic [4:0]        rsp_chip_id,
   output logic [4:0]        rsp_trigger_offset,
   output logic [9:0]        rsp_adc_value,
   output logic [11:0]       rsp_bunch_id,
   output logic [TIME_W-1:0] rsp_marker_time,
   output logic              rsp_has_marker
);

   localparam int MARKER_DEPTH = SOURCES * CHIPS_PER_SOURCE;
   localparam int ADDR_W = $clog2(MARKER_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MARKER_DEPTH - 1);

   logic [15:0] max_hits_ff, max_hits_in;
   logic        clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   logic accept;
   logic s1_advance;
   frame_dec_type dec;
   logic [ADDR_W-1:0] slot;
   logic [TIME_W-1:0] word_time;
   logic [TIME_W-1:0] rd_data;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [TIME_W-1:0] ram_wr_data;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_kind_ff, s1_kind_in;
   logic [2:0]        s1_status_ff, s1_status_in;
   logic              s1_seq_ff, s1_seq_in;
   logic              s1_ot_ff, s1_ot_in;
   logic [5:0]        s1_channel_ff, s1_channel_in;
   logic [7:0]        s1_tdc_ff, s1_tdc_in;
   logic [4:0]        s1_chip_ff, s1_chip_in;
   logic [4:0]        s1_trig_ff, s1_trig_in;
   logic [9:0]        s1_adc_ff, s1_adc_in;
   logic [11:0]       s1_bunch_ff, s1_bunch_in;
   logic [TIME_W-1:0] s1_time_ff, s1_time_in;
   logic              s1_use_ram_ff, s1_use_ram_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff;
   logic [2:0]        rsp_status_ff;
   logic              rsp_seq_ff;
   logic              rsp_ot_ff;
   logic [5:0]        rsp_channel_ff;
   logic [7:0]        rsp_tdc_ff;
   logic [4:0]        rsp_chip_ff;
   logic [4:0]        rsp_trig_ff;
   logic [9:0]        rsp_adc_ff;
   logic [11:0]       rsp_bunch_ff;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic              rsp_has_ff;

   assign csr_ready = 1'b1;
   assign max_hits_in = (csr_valid && csr_ready) ? csr_max_hits : max_hits_ff;

   assign clear_in = clear_ff && (clear_addr_ff != LAST_ADDR);
   assign clear_addr_in = clear_ff ? clear_addr_ff + ADDR_W'(1) : clear_addr_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clear_ff || (s1_valid_ff && !s1_advance);
   assign accept = req_valid && !req_stall;

   rfwd_frame #(
      .CHIPS_PER_SOURCE(CHIPS_PER_SOURCE),
      .HEADER_BYTES(HEADER_BYTES),
      .ADDR_W(ADDR_W)
   ) u_frame (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_type(req_type),
      .frame_counter(req_frame_counter),
      .data_id(req_data_id),
      .frame_bytes(req_frame_bytes),
      .word_high(req_word_high),
      .word_low(req_word_low),
      .max_hits(max_hits_ff),
      .dec(dec),
      .slot(slot)
   );

   assign word_time = {req_word_high, req_word_low[9:0]};

   assign ram_wr_en = clear_ff || (accept && (dec.kind == KIND_MARKER) && dec.slot_ok);
   assign ram_wr_addr = clear_ff ? clear_addr_ff : slot;
   assign ram_wr_data = clear_ff ? '0 : word_time;

   rfwd_ram #(
      .WIDTH(TIME_W),
      .DEPTH(MARKER_DEPTH)
   ) u_marker_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(accept),
      .rd_addr(slot),
      .rd_data(rd_data)
   );

   always_comb begin
      s1_kind_in = dec.kind;
      s1_status_in = '0;
      s1_seq_in = 1'b0;
      s1_ot_in = 1'b0;
      s1_channel_in = '0;
      s1_tdc_in = '0;
      s1_chip_in = '0;
      s1_trig_in = '0;
      s1_adc_in = '0;
      s1_bunch_in = '0;
      s1_time_in = '0;
      s1_use_ram_in = 1'b0;
      case (dec.kind)
         KIND_HEADER: begin
            s1_status_in = dec.status;
            s1_seq_in = dec.seq_err;
         end
         KIND_HIT: begin
            s1_ot_in = req_word_low[14];
            s1_channel_in = req_word_low[13:8];
            s1_tdc_in = req_word_low[7:0];
            s1_chip_in = dec.chip;
            s1_trig_in = req_word_high[31:27];
            s1_adc_in = req_word_high[21:12];
            s1_bunch_in = gray_to_bin(req_word_high[11:0]);
            s1_use_ram_in = dec.slot_ok;
         end
         KIND_MARKER: begin
            s1_chip_in = dec.chip;
            s1_time_in = word_time;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_time_in = s1_use_ram_ff ? rd_data : s1_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hits_ff <= MAX_HITS_RESET;
         clear_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_hits_ff <= max_hits_in;
         clear_ff <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= s1_kind_in;
         s1_status_ff <= s1_status_in;
         s1_seq_ff <= s1_seq_in;
         s1_ot_ff <= s1_ot_in;
         s1_channel_ff <= s1_channel_in;
         s1_tdc_ff <= s1_tdc_in;
         s1_chip_ff <= s1_chip_in;
         s1_trig_ff <= s1_trig_in;
         s1_adc_ff <= s1_adc_in;
         s1_bunch_ff <= s1_bunch_in;
         s1_time_ff <= s1_time_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      if (s1_advance) begin
         rsp_kind_ff <= s1_kind_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_seq_ff <= s1_seq_ff;
         rsp_ot_ff <= s1_ot_ff;
         rsp_channel_ff <= s1_channel_ff;
         rsp_tdc_ff <= s1_tdc_ff;
         rsp_chip_ff <= s1_chip_ff;
         rsp_trig_ff <= s1_trig_ff;
         rsp_adc_ff <= s1_adc_ff;
         rsp_bunch_ff <= s1_bunch_ff;
         rsp_time_ff <= rsp_time_in;
         rsp_has_ff <= rsp_time_in != '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_kind = rsp_kind_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_sequence_error = rsp_seq_ff;
   assign rsp_over_threshold = rsp_ot_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_tdc_value = rsp_tdc_ff;
   assign rsp_chip_id = rsp_chip_ff;
   assign rsp_trigger_offset = rsp_trig_ff;
   assign rsp_adc_value = rsp_adc_ff;
   assign rsp_bunch_id = rsp_bunch_ff;
   assign rsp_marker_time = rsp_time_ff;
   assign rsp_has_marker = rsp_has_ff;

endmodule

FILE: rtl/rfwd_checker.sv
module rfwd_checker
   import rfwd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_type,
   input logic [15:0]       req_frame_bytes,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_item_kind,
   input logic [2:0]        rsp_frame_status,
   input logic              rsp_sequence_error,
   input logic [TIME_W-1:0] rsp_marker_time,
   input logic              rsp_has_marker
);

   // The timestamp RAM is being cleared right after reset, so no beat may enter.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input taken during the clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_type && (req_frame_bytes < MIN_FRAME_BYTES)
       && !rsp_stall ##1 !rsp_stall)
      |=> rsp_valid && (rsp_item_kind == KIND_HEADER)
          && (rsp_frame_status == STATUS_UNDERSIZE) && !rsp_sequence_error)
      else $error("short header not answered as undersize two cycles later");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_marker == (rsp_marker_time != '0))
                    && ((rsp_item_kind != KIND_HEADER) || (rsp_marker_time == '0)))
      else $error("marker flag or header timestamp inconsistent");

endmodule

bind readout_frame_word_decoder rfwd_checker u_checker (.*);

FILE: tb/sv/tb_readout_frame_word_decoder.sv
`timescale 1ns / 100ps

module tb_readout_frame_word_decoder;
   import rfwd_pkg::*;

   localparam logic TYPE_HEADER = 1'b0;
   localparam logic TYPE_WORD = 1'b1;
   localparam int STAMP_DEPTH = SOURCES * CHIPS_PER_SOURCE_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int TAIL_CYCLES = 10;
   localparam int PRINT_LIMIT = 60;

   typedef struct packed {
      logic        kind;
      logic [31:0] counter;
      logic [31:0] id;
      logic [15:0] bytes;
      logic [31:0] hi;
      logic [15:0] lo;
   } readout_item_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        status;
      logic              seq_err;
      logic              over_thr;
      logic [5:0]        channel;
      logic [7:0]        tdc;
      logic [4:0]        chip;
      logic [4:0]        trig;
      logic [9:0]        adc;
      logic [11:0]       bunch;
      logic [TIME_W-1:0] stamp;
      logic              has_stamp;
   } decoded_type;

   logic              clock;
   logic              reset;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_max_hits;
   logic              req_valid;
   logic              req_stall;
   logic              req_type;
   logic [31:0]       req_frame_counter;
   logic [31:0]       req_data_id;
   logic [15:0]       req_frame_bytes;
   logic [31:0]       req_word_high;
   logic [15:0]       req_word_low;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_item_kind;
   logic [2:0]        rsp_frame_status;
   logic              rsp_sequence_error;
   logic              rsp_over_threshold;
   logic [5:0]        rsp_channel;
   logic [7:0]        rsp_tdc_value;
   logic [4:0]        rsp_chip_id;
   logic [4:0]        rsp_trigger_offset;
   logic [9:0]        rsp_adc_value;
   logic [11:0]       rsp_bunch_id;
   logic [TIME_W-1:0] rsp_marker_time;
   logic              rsp_has_marker;

   logic [TIME_W-1:0] stamp_store [STAMP_DEPTH];
   logic [31:0]       next_frame_no;
   logic [3:0]        frame_src;
   logic              frame_is_open;
   logic [15:0]       hit_count;
   logic [15:0]       hit_limit;

   decoded_type       expected_results [$];
   decoded_type       oldest;
   int                error_count = 0;
   int                items_sent = 0;
   int                cycle_count = 0;
   int                gap_max = 0;
   int                burst_left = 0;
   int                stall_pct = 0;
   int                stall_run = 0;

   readout_frame_word_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_hits       (csr_max_hits),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_frame_counter  (req_frame_counter),
      .req_data_id        (req_data_id),
      .req_frame_bytes    (req_frame_bytes),
      .req_word_high      (req_word_high),
      .req_word_low       (req_word_low),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_item_kind      (rsp_item_kind),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_sequence_error (rsp_sequence_error),
      .rsp_over_threshold (rsp_over_threshold),
      .rsp_channel        (rsp_channel),
      .rsp_tdc_value      (rsp_tdc_value),
      .rsp_chip_id        (rsp_chip_id),
      .rsp_trigger_offset (rsp_trigger_offset),
      .rsp_adc_value      (rsp_adc_value),
      .rsp_bunch_id       (rsp_bunch_id),
      .rsp_marker_time    (rsp_marker_time),
      .rsp_has_marker     (rsp_has_marker)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [11:0] gray_decode(input logic [11:0] g);
      logic [11:0] b;
      b = g;
      b = b ^ (b >> 1);
      b = b ^ (b >> 2);
      b = b ^ (b >> 4);
      b = b ^ (b >> 8);
      return b;
   endfunction

   function automatic logic stamp_slot(input logic [4:0] chip, output int slot);
      slot = 0;
      if (frame_src < 1 || frame_src > SOURCES || chip >= CHIPS_PER_SOURCE_DEF)
         return 1'b0;
      slot = (int'(frame_src) - 1) * CHIPS_PER_SOURCE_DEF + int'(chip);
      return slot < STAMP_DEPTH;
   endfunction

   function automatic decoded_type decode_item(input readout_item_type it);
      decoded_type r;
      int          slot;
      r = '0;
      if (it.kind == TYPE_HEADER) begin
         r.kind = KIND_HEADER;
         if (it.bytes < MIN_FRAME_BYTES) begin
            r.status = STATUS_UNDERSIZE;
         end else if (it.counter == END_PATTERN) begin
            r.status = STATUS_END;
         end else begin
            r.seq_err = (it.counter != next_frame_no);
            next_frame_no = it.counter + 32'd1;
            if (int'(it.bytes) < HEADER_BYTES_DEF + WORD_BYTES)
               r.status = STATUS_UNDERSIZE;
            else if ((it.id & SIG_MASK) != SIG_VALUE)
               r.status = STATUS_UNKNOWN_ID;
            else if (it.id[7:4] == 4'd0)
               r.status = STATUS_BAD_FE;
            else if (((int'(it.bytes) - HEADER_BYTES_DEF) % WORD_BYTES) != 0)
               r.status = STATUS_BAD_LENGTH;
            else
               r.status = STATUS_OK;
         end
         frame_is_open = 1'b0;
         hit_count = '0;
         if (r.status == STATUS_OK) begin
            frame_is_open = 1'b1;
            frame_src = it.id[7:4];
         end
      end else if (!frame_is_open || hit_count >= hit_limit) begin
         r.kind = KIND_DROP;
      end else if (it.lo[15]) begin
         r.kind = KIND_HIT;
         r.over_thr = it.lo[14];
         r.channel = it.lo[13:8];
         r.tdc = it.lo[7:0];
         r.chip = it.hi[26:22];
         r.trig = it.hi[31:27];
         r.adc = it.hi[21:12];
         r.bunch = gray_decode(it.hi[11:0]);
         if (stamp_slot(r.chip, slot))
            r.stamp = stamp_store[slot];
         r.has_stamp = (r.stamp != '0);
         if (hit_count != 16'hffff)
            hit_count = hit_count + 16'd1;
      end else begin
         r.kind = KIND_MARKER;
         r.chip = it.lo[14:10];
         r.stamp = {it.hi, it.lo[9:0]};
         r.has_stamp = (r.stamp != '0);
         if (stamp_slot(r.chip, slot))
            stamp_store[slot] = r.stamp;
      end
      return r;
   endfunction

   function automatic readout_item_type header_item(input logic [31:0] counter,
                                                    input logic [31:0] id,
                                                    input logic [15:0] bytes);
      readout_item_type it;
      it.kind = TYPE_HEADER;
      it.counter = counter;
      it.id = id;
      it.bytes = bytes;
      it.hi = $urandom;
      it.lo = 16'($urandom);
      return it;
   endfunction

   function automatic readout_item_type word_item(input logic [31:0] hi,
                                                  input logic [15:0] lo);
      readout_item_type it;
      it.kind = TYPE_WORD;
      it.counter = $urandom;
      it.id = $urandom;
      it.bytes = 16'($urandom);
      it.hi = hi;
      it.lo = lo;
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", 64'(rsp_item_kind),
                            64'(0));
         end else begin
            oldest = expected_results.pop_front();
            check_field("item_kind", 64'(rsp_item_kind), 64'(oldest.kind));
            check_field("frame_status", 64'(rsp_frame_status), 64'(oldest.status));
            check_field("sequence_error", 64'(rsp_sequence_error), 64'(oldest.seq_err));
            check_field("over_threshold", 64'(rsp_over_threshold), 64'(oldest.over_thr));
            check_field("channel", 64'(rsp_channel), 64'(oldest.channel));
            check_field("tdc_value", 64'(rsp_tdc_value), 64'(oldest.tdc));
            check_field("chip_id", 64'(rsp_chip_id), 64'(oldest.chip));
            check_field("trigger_offset", 64'(rsp_trigger_offset), 64'(oldest.trig));
            check_field("adc_value", 64'(rsp_adc_value), 64'(oldest.adc));
            check_field("bunch_id", 64'(rsp_bunch_id), 64'(oldest.bunch));
            check_field("marker_time", 64'(rsp_marker_time), 64'(oldest.stamp));
            check_field("has_marker", 64'(rsp_has_marker), 64'(oldest.has_stamp));
         end
      end
   end

   task automatic send_item(input readout_item_type it);
      req_type <= it.kind;
      req_frame_counter <= it.counter;
      req_data_id <= it.id;
      req_frame_bytes <= it.bytes;
      req_word_high <= it.hi;
      req_word_low <= it.lo;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_results.push_back(decode_item(it));
      items_sent++;
      @(negedge clock);
      if (gap_max > 0) begin
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_max_hits(input logic [15:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_hits <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      hit_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [4:0] pick_chip();
      return ($urandom_range(3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
   endfunction

   task automatic send_marker(input logic [4:0] chip);
      logic [31:0] hi;
      logic [9:0]  fine;
      hi = $urandom;
      fine = 10'($urandom);
      if ($urandom_range(15) == 0) begin
         hi = '0;
         fine = '0;
      end
      send_item(word_item(hi, {1'b0, chip, fine}));
   endtask

   task automatic send_hit(input logic [4:0] chip);
      logic [31:0] hi;
      hi = $urandom;
      hi[26:22] = chip;
      send_item(word_item(hi, {1'b1, 15'($urandom)}));
   endtask

   task automatic send_frame();
      logic [31:0] counter;
      logic [3:0]  fe;
      logic [15:0] bytes;
      int          n_words;
      counter = ($urandom_range(9) == 0) ? 32'($urandom) : next_frame_no;
      fe = ($urandom_range(9) < 7) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(1, 15));
      bytes = ($urandom_range(9) == 0) ? 16'(16 + 6 * $urandom_range(1, 10919))
                                       : 16'(16 + 6 * $urandom_range(1, 40));
      send_item(header_item(counter, {SIG_VALUE[31:8], fe, 4'($urandom)}, bytes));
      n_words = $urandom_range(0, 14);
      repeat (n_words) begin
         if ($urandom_range(99) < 35)
            send_marker(pick_chip());
         else
            send_hit(pick_chip());
      end
   endtask

   task automatic send_noise();
      logic [31:0] id;
      logic [15:0] bytes;
      case ($urandom_range(3))
         0: begin
            send_item(header_item($urandom, $urandom, 16'($urandom)));
         end
         1: begin
            id = {SIG_VALUE[31:8], 8'($urandom)};
            bytes = 16'(16 + 6 * $urandom_range(1, 30));
            case ($urandom_range(2))
               0: id[7:4] = 4'd0;
               1: bytes = bytes + 16'($urandom_range(1, 5));
               default: bytes = 16'($urandom_range(0, 21));
            endcase
            send_item(header_item(next_frame_no, id, bytes));
            repeat ($urandom_range(0, 3)) send_hit(pick_chip());
         end
         2: begin
            send_item(word_item($urandom, 16'($urandom)));
         end
         default: begin
            send_item(header_item(END_PATTERN, $urandom, 16'($urandom)));
         end
      endcase
   endtask

   task automatic test_header_checks();
      send_item(word_item(32'hffffffff, 16'hffff));
      send_item(header_item(32'd0, 32'h564d3310, 16'd0));
      send_item(header_item(END_PATTERN, 32'h564d3310, 16'd3));
      send_item(header_item(END_PATTERN, 32'h564d3310, 16'd4));
      send_item(header_item(32'd0, 32'h564d3310, 16'd21));
      send_item(header_item(32'd5, 32'h564d3310, 16'd22));
      send_item(word_item(32'h00000000, 16'h8000));
      send_item(header_item(32'd6, 32'h564d3300, 16'd22));
      send_item(word_item(32'h00000000, 16'h0000));
      send_item(header_item(32'd7, 32'h12345678, 16'd22));
      send_item(header_item(32'd8, 32'h564d33f0, 16'hffff));
   endtask

   task automatic test_marker_and_hit_decode();
      send_item(header_item(32'hffffffff, 32'h564d33ff, 16'd65530));
      send_item(word_item(32'hffffffff, 16'h7fff));
      send_item(word_item(32'hffffffff, 16'hffff));
      send_item(word_item(32'h00000000, 16'h7c00));
      send_item(word_item(32'h07c00800, 16'h8000));
      send_item(header_item(32'd0, 32'h564d3320, 16'd22));
      send_item(word_item(32'h00000001, 16'h7c01));
      send_item(word_item(32'h07c00555, 16'hc0a5));
   endtask

   task automatic test_hit_limit();
      write_max_hits(16'd1);
      send_item(header_item(next_frame_no, 32'h564d3330, 16'd28));
      send_item(word_item(32'h0000abcd, 16'h8123));
      send_item(word_item(32'h0000abcd, 16'h8123));
      send_item(word_item(32'h12345678, 16'h0456));
      send_item(header_item(next_frame_no, 32'h564d3330, 16'd28));
      send_item(word_item(32'hfedcba98, 16'hf00f));
   endtask

   task automatic test_random_traffic(input logic [15:0] limit, input int n_items,
                                      input int gaps, input int stall);
      int target;
      int pause_at;
      bit paused;
      write_max_hits(limit);
      gap_max = gaps;
      burst_left = 0;
      stall_pct = stall;
      target = items_sent + n_items;
      pause_at = items_sent + n_items / 2;
      paused = 1'b0;
      while (items_sent < target) begin
         if (!paused && items_sent >= pause_at) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 85)
            send_frame();
         else
            send_noise();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_max_hits = '0;
      req_valid = 1'b0;
      req_type = TYPE_HEADER;
      req_frame_counter = '0;
      req_data_id = '0;
      req_frame_bytes = '0;
      req_word_high = '0;
      req_word_low = '0;
      for (int i = 0; i < STAMP_DEPTH; i++)
         stamp_store[i] = '0;
      next_frame_no = '0;
      frame_src = '0;
      frame_is_open = 1'b0;
      hit_count = '0;
      hit_limit = MAX_HITS_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_checks();
      test_marker_and_hit_decode();
      test_hit_limit();
      test_random_traffic(16'd65535, 240, 0, 0);
      test_random_traffic(16'd1, 200, 6, 30);
      test_random_traffic(16'd3, 240, 3, 50);
      test_random_traffic(16'($urandom_range(2, 12)), 240, 8, 20);
      test_random_traffic(16'd1024, 250, 4, 40);
      test_random_traffic(16'd65535, 230, 2, 10);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
